// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// check prop on every rising edge of clk, skipped while rst is high
`define AR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ring coverage assertion failed");

// check prop on every rising edge of clk, reset included
`define AR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ring coverage assertion failed");

`else

`define AR_ASSERT(lbl, clk, rst, prop)
`define AR_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: rtl/core/aaring_pkg.sv
// ---------------------------------------------------------------------------
// aaring_pkg
// Widths, constants and item types of the antialiased ring coverage block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aaring_pkg;

  // texture and number format
  localparam int MAX_SIDE  = 1024;
  localparam int FRAC_BITS = 8;
  localparam int PIX_W     = 10;
  localparam int REG_W     = 17;
  localparam int ALPHA_W   = 8;
  localparam int CFG_IDX_W = 1;

  // derived datapath widths (distances in Q(FRAC_BITS+1))
  localparam int SIDE_W  = $clog2(MAX_SIDE) + 1;
  localparam int COORD_W = PIX_W + FRAC_BITS + 1;
  localparam int RAD2_W  = REG_W + 1;
  localparam int DELTA_W = (COORD_W > RAD2_W) ? COORD_W : RAD2_W;
  localparam int SQ_W    = 2 * DELTA_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int ROOT_W  = (SUM_W + 1) / 2;
  localparam int REM_W   = 2 * ROOT_W;
  localparam int DIFF_W  = ((ROOT_W > RAD2_W) ? ROOT_W : RAD2_W) + 2;
  localparam int OFF_W   = DIFF_W - 1;
  localparam int EDGE_W  = REG_W + 1;
  localparam int PROD_W  = EDGE_W + ALPHA_W;

  localparam logic [ALPHA_W-1:0] ALPHA_FULL = '1;
  localparam logic [23:0]        WHITE_RGB  = 24'hFFFFFF;

  // register map and reset values
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THICKNESS = 1'b1;
  localparam logic [REG_W-1:0]     RADIUS_RESET  = 17'd65536;
  localparam logic [REG_W-1:0]     THICK_RESET   = 17'd768;

  // coverage class decided before the alpha ramp is scaled
  typedef enum logic [1:0] {
    COV_NONE,
    COV_RAMP,
    COV_FULL
  } cov_t;

  typedef struct packed {
    logic [REG_W-1:0] radius_q8;
    logic [REG_W-1:0] thickness_q8;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [31:0]        pixel_word;
    logic               outside_texture;
  } out_item_t;

  // squared distance from circle center
  typedef struct packed {
    logic [SUM_W-1:0] dist_sq;
    logic             outside;
  } sum_item_t;

  // distance from circle center, floor, Q(FRAC_BITS+1)
  typedef struct packed {
    logic [ROOT_W-1:0] distance;
    logic              outside;
  } root_item_t;

endpackage

`default_nettype wire

// File: rtl/core/antialiased_ring_alpha.sv
// ---------------------------------------------------------------------------
// antialiased_ring_alpha
// Coverage alpha and white RGBA8888 word for one texel of a ring texture.
// ---------------------------------------------------------------------------
// Takes one texel (x, y) per clock and returns its stroke coverage. The
// pipeline is 3 stages of offset/square/sum, 20 square root stages
// (one root bit each) and 3 stages of ring offset, coverage class and alpha
// ramp; each stage holds its item on a stall, so throughput is one item per
// clock whenever the output side keeps taking results. Registers are written
// through cfg_we/cfg_index/cfg_data and must only change while the pipeline
// is empty.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module antialiased_ring_alpha (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [aaring_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [aaring_pkg::REG_W-1:0]     cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire aaring_pkg::in_item_t             in_item,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output aaring_pkg::out_item_t                 out_item
);

  aaring_pkg::cfg_t       cfg;
  logic                   sum_valid, sum_ready;
  aaring_pkg::sum_item_t  sum_item;
  logic                   root_valid, root_ready;
  aaring_pkg::root_item_t root_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius_q8    <= aaring_pkg::RADIUS_RESET;
      cfg.thickness_q8 <= aaring_pkg::THICK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        aaring_pkg::REG_RADIUS:    cfg.radius_q8    <= cfg_data;
        aaring_pkg::REG_THICKNESS: cfg.thickness_q8 <= cfg_data;
        default: ;
      endcase
    end
  end

  // squared distance
  aaring_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_item  (sum_item)
  );

  // distance
  aaring_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_item   (sum_item),
    .out_valid (root_valid),
    .out_ready (root_ready),
    .out_item  (root_item)
  );

  // coverage
  aaring_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (root_valid),
    .in_ready  (root_ready),
    .in_item   (root_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // texels outside the texture are never covered
  `AR_ASSERT(a_outside_clear, clk, rst, out_valid && out_item.outside_texture |-> out_item.alpha == '0)
  // pixel word is white with alpha in the low byte
  `AR_ASSERT(a_word_rgb, clk, rst, out_valid |-> out_item.pixel_word[31:8] == aaring_pkg::WHITE_RGB)
  `AR_ASSERT(a_word_alpha, clk, rst, out_valid |-> out_item.pixel_word[7:0] == out_item.alpha)
  // pipeline is empty and ready right after reset
  `AR_ASSERT_ALWAYS(a_ready_after_rst, clk, $past(rst) && !rst |-> in_ready && !out_valid)

endmodule

`default_nettype wire

// File: rtl/core/aaring_front.sv
// ---------------------------------------------------------------------------
// aaring_front
// Texel center offsets, squares and squared distance: three stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aaring_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire aaring_pkg::cfg_t     cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire aaring_pkg::in_item_t in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output aaring_pkg::sum_item_t     out_item
);

  // stage A: offsets from center
  logic                               va;
  logic [aaring_pkg::DELTA_W-1:0]     dxa, dya;
  logic                               outa;
  // stage B: squares
  logic                               vb;
  logic [aaring_pkg::SQ_W-1:0]        sqx, sqy;
  logic                               outb;
  // stage C: sum
  logic                               vc;
  logic [aaring_pkg::SUM_W-1:0]       sumc;
  logic                               outc;

  logic rdy_a, rdy_b, rdy_c;

  logic [aaring_pkg::DELTA_W-1:0] cx, cy, r2;
  logic [aaring_pkg::DELTA_W-1:0] dx, dy;
  logic [aaring_pkg::REG_W-1:0]   side_raw;
  logic [aaring_pkg::SIDE_W-1:0]  side;
  logic                           outside;

  // each stage takes a new item when empty or when the next one moves
  assign rdy_c    = !vc || out_ready;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  // texel center (x + 0.5) and doubled radius, both Q(F+1)
  assign cx = aaring_pkg::DELTA_W'({in_item.pixel_x, 1'b1,
                                    {aaring_pkg::FRAC_BITS{1'b0}}});
  assign cy = aaring_pkg::DELTA_W'({in_item.pixel_y, 1'b1,
                                    {aaring_pkg::FRAC_BITS{1'b0}}});
  assign r2 = aaring_pkg::DELTA_W'({cfg.radius_q8, 1'b0});
  assign dx = (cx >= r2) ? (cx - r2) : (r2 - cx);
  assign dy = (cy >= r2) ? (cy - r2) : (r2 - cy);

  // texture side = floor(2 * radius), saturated
  assign side_raw = cfg.radius_q8 >> (aaring_pkg::FRAC_BITS - 1);
  assign side     = (side_raw > aaring_pkg::REG_W'(aaring_pkg::MAX_SIDE)) ?
                    aaring_pkg::SIDE_W'(aaring_pkg::MAX_SIDE) :
                    aaring_pkg::SIDE_W'(side_raw);
  assign outside  = (aaring_pkg::SIDE_W'(in_item.pixel_x) >= side) ||
                    (aaring_pkg::SIDE_W'(in_item.pixel_y) >= side);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      dxa  <= dx;
      dya  <= dy;
      outa <= outside;
    end
    if (rdy_b && va) begin
      sqx  <= dxa * dxa;
      sqy  <= dya * dya;
      outb <= outa;
    end
    if (rdy_c && vb) begin
      sumc <= aaring_pkg::SUM_W'(sqx) + aaring_pkg::SUM_W'(sqy);
      outc <= outb;
    end
  end

  assign out_valid        = vc;
  assign out_item.dist_sq = sumc;
  assign out_item.outside = outc;

endmodule

`default_nettype wire

// File: rtl/core/aaring_sqrt.sv
// ---------------------------------------------------------------------------
// aaring_sqrt
// Pipelined restoring square root: one root bit per stage, floor result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aaring_sqrt (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire aaring_pkg::sum_item_t in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output aaring_pkg::root_item_t     out_item
);

  localparam int N = aaring_pkg::ROOT_W;

  // per-stage state: remainder n - q*q, partial root q, flags
  logic [aaring_pkg::REM_W-1:0]  rem  [N-1];
  logic [aaring_pkg::ROOT_W-1:0] root [N];
  logic                          outs [N];
  logic                          v    [N];
  logic                          rdy  [N+1];

  assign rdy[N]   = out_ready;
  assign in_ready = rdy[0];

  for (genvar s = 0; s < N; s++) begin : g_step
    // root bit decided in this stage
    localparam int K = N - 1 - s;

    logic [aaring_pkg::REM_W-1:0]  rem_in, trial;
    logic [aaring_pkg::ROOT_W-1:0] root_in, root_set;
    logic                          out_in, v_in, take;

    if (s == 0) begin : g_first
      assign rem_in  = aaring_pkg::REM_W'(in_item.dist_sq);
      assign root_in = '0;
      assign out_in  = in_item.outside;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem[s-1];
      assign root_in = root[s-1];
      assign out_in  = outs[s-1];
      assign v_in    = v[s-1];
    end

    // (q + 2^K)^2 - q^2 = q*2^(K+1) + 4^K
    assign trial    = (aaring_pkg::REM_W'(root_in) << (K + 1)) +
                      (aaring_pkg::REM_W'(1) << (2 * K));
    assign take     = (rem_in >= trial);
    assign root_set = root_in | (aaring_pkg::ROOT_W'(1) << K);

    assign rdy[s] = !v[s] || rdy[s+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (rdy[s]) begin
        v[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && v_in) begin
        root[s] <= take ? root_set : root_in;
        outs[s] <= out_in;
      end
    end

    // the last stage needs no remainder
    if (s < N - 1) begin : g_rem
      logic [aaring_pkg::REM_W-1:0] rem_sub;

      assign rem_sub = rem_in - trial;

      always_ff @(posedge clk) begin
        if (rdy[s] && v_in) begin
          rem[s] <= take ? rem_sub : rem_in;
        end
      end
    end
  end

  assign out_valid         = v[N-1];
  assign out_item.distance = root[N-1];
  assign out_item.outside  = outs[N-1];

endmodule

`default_nettype wire

// File: rtl/core/aaring_back.sv
// ---------------------------------------------------------------------------
// aaring_back
// Offset from the stroke ring, coverage class and alpha ramp: three stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aaring_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire aaring_pkg::cfg_t       cfg,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire aaring_pkg::root_item_t in_item,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output aaring_pkg::out_item_t       out_item
);

  // stage 1: offset from ring
  logic                             v1;
  logic [aaring_pkg::OFF_W-1:0]     off1;
  logic                             out1;
  // stage 2: class and ramp factor
  logic                             v2;
  aaring_pkg::cov_t                 cls2;
  logic [aaring_pkg::EDGE_W-1:0]    fact2;
  logic                             out2;
  // stage 3: output register
  logic                             v3;
  aaring_pkg::out_item_t            item3;

  logic rdy_1, rdy_2, rdy_3;

  logic signed [aaring_pkg::DIFF_W-1:0] centre, diff, core;
  logic [aaring_pkg::DIFF_W-1:0]        off_w;
  logic [aaring_pkg::EDGE_W-1:0]        edge_pt;
  logic [aaring_pkg::OFF_W-1:0]         fact_w;
  logic                                 core_hit, edge_hit;
  aaring_pkg::cov_t                     cls;
  logic [aaring_pkg::PROD_W-1:0]        prod, scaled;
  logic [aaring_pkg::ALPHA_W-1:0]       alpha;

  assign rdy_3    = !v3 || out_ready;
  assign rdy_2    = !v2 || rdy_3;
  assign rdy_1    = !v1 || rdy_2;
  assign in_ready = rdy_1;

  // ring center radius = 2r - t in Q(F+1); offset = |dist - center|
  assign centre = $signed(aaring_pkg::DIFF_W'({cfg.radius_q8, 1'b0})) -
                  $signed(aaring_pkg::DIFF_W'(cfg.thickness_q8));
  assign diff   = $signed(aaring_pkg::DIFF_W'(in_item.distance)) - centre;
  assign off_w  = diff[aaring_pkg::DIFF_W-1] ? aaring_pkg::DIFF_W'(-diff) :
                                               aaring_pkg::DIFF_W'(diff);

  // core limit t - half pixel may be negative (no core)
  assign core     = $signed(aaring_pkg::DIFF_W'(cfg.thickness_q8)) -
                    $signed(aaring_pkg::DIFF_W'(2 ** aaring_pkg::FRAC_BITS));
  assign edge_pt  = aaring_pkg::EDGE_W'(cfg.thickness_q8) +
                    aaring_pkg::EDGE_W'(2 ** aaring_pkg::FRAC_BITS);
  assign core_hit = !core[aaring_pkg::DIFF_W-1] &&
                    (off1 < core[aaring_pkg::OFF_W-1:0]);
  assign edge_hit = off1 < aaring_pkg::OFF_W'(edge_pt);
  assign fact_w   = aaring_pkg::OFF_W'(edge_pt) - off1;

  always_comb begin
    if (out1) begin
      cls = aaring_pkg::COV_NONE;
    end else if (core_hit) begin
      cls = aaring_pkg::COV_FULL;
    end else if (edge_hit) begin
      cls = aaring_pkg::COV_RAMP;
    end else begin
      cls = aaring_pkg::COV_NONE;
    end
  end

  // ramp: floor(fact * 255 / 2^(F+1)), capped
  assign prod   = (aaring_pkg::PROD_W'(fact2) << aaring_pkg::ALPHA_W) -
                  aaring_pkg::PROD_W'(fact2);
  assign scaled = prod >> (aaring_pkg::FRAC_BITS + 1);

  always_comb begin
    case (cls2)
      aaring_pkg::COV_FULL: begin
        alpha = aaring_pkg::ALPHA_FULL;
      end
      aaring_pkg::COV_RAMP: begin
        alpha = (scaled > aaring_pkg::PROD_W'(aaring_pkg::ALPHA_FULL)) ?
                aaring_pkg::ALPHA_FULL : scaled[aaring_pkg::ALPHA_W-1:0];
      end
      default: begin
        alpha = '0;
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy_1) v1 <= in_valid;
      if (rdy_2) v2 <= v1;
      if (rdy_3) v3 <= v2;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdy_1 && in_valid) begin
      off1 <= off_w[aaring_pkg::OFF_W-1:0];
      out1 <= in_item.outside;
    end
    if (rdy_2 && v1) begin
      cls2  <= cls;
      fact2 <= fact_w[aaring_pkg::EDGE_W-1:0];
      out2  <= out1;
    end
    if (rdy_3 && v2) begin
      item3.alpha           <= alpha;
      item3.pixel_word      <= {aaring_pkg::WHITE_RGB, alpha};
      item3.outside_texture <= out2;
    end
  end

  assign out_valid = v3;
  assign out_item  = item3;

endmodule

`default_nettype wire

// File: tb/tb_antialiased_ring_alpha.sv
// ----------------------------------------------------------------------------
// tb_antialiased_ring_alpha
// Self-checking testbench for the ring coverage block. Texel items go in over
// a valid/ready channel and a scoreboard predicts each coverage item in order.
// Ring settings change only while the pipeline is empty. Idling on both
// sides is randomized per phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_antialiased_ring_alpha;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;   // pipeline is 26 deep
  localparam int PHASE_ITEMS    = 142;

  // Scoreboard: ring settings, coverage predictor, queue of expected items
  class ring_alpha_board;
    logic [aaring_pkg::REG_W-1:0] radius;
    logic [aaring_pkg::REG_W-1:0] thickness;
    aaring_pkg::out_item_t        expected_cov[$];
    int unsigned                  mismatches;

    function new();
      radius     = aaring_pkg::RADIUS_RESET;
      thickness  = aaring_pkg::THICK_RESET;
      mismatches = 0;
    endfunction

    function void set_rings(logic [aaring_pkg::REG_W-1:0] r,
                            logic [aaring_pkg::REG_W-1:0] t);
      radius    = r;
      thickness = t;
    endfunction

    // largest root with root*root <= n
    function longint floor_sqrt(longint n);
      longint lo, hi, mid;
      lo = 0;
      hi = longint'(1) << 21;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (mid * mid <= n) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    // distances are in Q(FRAC_BITS+1): thickness/2 and half a pixel are exact
    function aaring_pkg::out_item_t predict_coverage(aaring_pkg::in_item_t px);
      longint side, r2, t, half, cx, cy, dx, dy, distance, centre, off;
      longint core_lim, edge_lim, a;
      aaring_pkg::out_item_t res;
      side = (longint'(radius) * 2) >> aaring_pkg::FRAC_BITS;
      if (side > aaring_pkg::MAX_SIDE) side = aaring_pkg::MAX_SIDE;
      a = 0;
      res.outside_texture = (longint'(px.pixel_x) >= side) ||
                            (longint'(px.pixel_y) >= side);
      if (!res.outside_texture) begin
        half = longint'(1) << aaring_pkg::FRAC_BITS;
        r2   = longint'(radius) * 2;
        t    = longint'(thickness);
        cx   = (longint'(px.pixel_x) << (aaring_pkg::FRAC_BITS + 1)) + half;
        cy   = (longint'(px.pixel_y) << (aaring_pkg::FRAC_BITS + 1)) + half;
        dx   = (cx > r2) ? cx - r2 : r2 - cx;
        dy   = (cy > r2) ? cy - r2 : r2 - cy;
        distance = floor_sqrt(dx * dx + dy * dy);
        centre = r2 - t;          // negative when the stroke is wider than the disc
        off    = distance - centre;
        if (off < 0) off = -off;
        core_lim = t - half;
        edge_lim = t + half;
        if (off < core_lim) begin
          a = 255;
        end else if (off < edge_lim) begin
          a = ((edge_lim - off) * 255) >> (aaring_pkg::FRAC_BITS + 1);
          if (a > 255) a = 255;
        end
      end
      res.alpha      = a[7:0];
      res.pixel_word = {aaring_pkg::WHITE_RGB, a[7:0]};
      return res;
    endfunction

    function void note_pixel(aaring_pkg::in_item_t px);
      expected_cov.push_back(predict_coverage(px));
    endfunction

    function void check_coverage(aaring_pkg::out_item_t got);
      aaring_pkg::out_item_t want;
      if (expected_cov.size() == 0) begin
        $display("%0t: unexpected item alpha=%0d word=%h outside=%0d",
                 $time, got.alpha, got.pixel_word, got.outside_texture);
        mismatches++;
        return;
      end
      want = expected_cov.pop_front();
      if (got.alpha !== want.alpha) begin
        $display("%0t: alpha expected %0d actual %0d", $time, want.alpha, got.alpha);
        mismatches++;
      end
      if (got.pixel_word !== want.pixel_word) begin
        $display("%0t: pixel_word expected %h actual %h", $time,
                 want.pixel_word, got.pixel_word);
        mismatches++;
      end
      if (got.outside_texture !== want.outside_texture) begin
        $display("%0t: outside_texture expected %0d actual %0d", $time,
                 want.outside_texture, got.outside_texture);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_cov.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [aaring_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [aaring_pkg::REG_W-1:0]     cfg_data;
  logic                             in_valid;
  logic                             in_ready;
  aaring_pkg::in_item_t             in_item;
  logic                             out_valid;
  logic                             out_ready;
  aaring_pkg::out_item_t            out_item;

  int unsigned     send_idle = 0;
  int unsigned     recv_idle = 0;
  int unsigned     idle_cycles;
  ring_alpha_board board = new();

  antialiased_ring_alpha u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: random back-pressure, checking and stall watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && out_ready) board.check_coverage(out_item);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_antialiased_ring_alpha NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // One texel item; valid holds until accepted
  task automatic send_texel(input aaring_pkg::in_item_t px);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_pixel(px);
  endtask

  task automatic send_xy(input int x, input int y);
    aaring_pkg::in_item_t px;
    px.pixel_x = x[aaring_pkg::PIX_W-1:0];
    px.pixel_y = y[aaring_pkg::PIX_W-1:0];
    send_texel(px);
  endtask

  // Stop sending, wait for every coverage item, then let the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both ring registers, back to back; only called with the pipeline empty
  task automatic write_rings(input int unsigned r, input int unsigned t);
    cfg_we    <= 1'b1;
    cfg_index <= aaring_pkg::REG_RADIUS;
    cfg_data  <= r[aaring_pkg::REG_W-1:0];
    @(posedge clk);
    cfg_index <= aaring_pkg::REG_THICKNESS;
    cfg_data  <= t[aaring_pkg::REG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_rings(r[aaring_pkg::REG_W-1:0], t[aaring_pkg::REG_W-1:0]);
  endtask

  // Random texel: mostly inside the texture, many near the stroke ring
  function automatic aaring_pkg::in_item_t random_texel(int unsigned r, int unsigned t);
    int side, ctr, ring, pos, other, k;
    aaring_pkg::in_item_t px;
    side = int'((r * 2) >> aaring_pkg::FRAC_BITS);
    if (side > aaring_pkg::MAX_SIDE) side = aaring_pkg::MAX_SIDE;
    k = $urandom_range(0, 99);
    px.pixel_x = aaring_pkg::PIX_W'($urandom);
    px.pixel_y = aaring_pkg::PIX_W'($urandom);
    if (side != 0 && k < 45) begin
      px.pixel_x = aaring_pkg::PIX_W'($urandom_range(0, side - 1));
      px.pixel_y = aaring_pkg::PIX_W'($urandom_range(0, side - 1));
    end else if (side != 0 && k < 85) begin
      ctr  = int'(r >> aaring_pkg::FRAC_BITS);
      ring = (r * 2 > t) ? int'((r * 2 - t) >> (aaring_pkg::FRAC_BITS + 1)) : 0;
      pos  = $urandom_range(0, 1) ? ctr - ring : ctr + ring;
      pos  = pos + int'($urandom_range(0, 6)) - 3;
      other = ctr + int'($urandom_range(0, 4)) - 2;
      if (pos < 0) pos = 0;
      if (pos > side - 1) pos = side - 1;
      if (other < 0) other = 0;
      if (other > side - 1) other = side - 1;
      if ($urandom_range(0, 1)) begin
        px.pixel_x = pos[aaring_pkg::PIX_W-1:0];
        px.pixel_y = other[aaring_pkg::PIX_W-1:0];
      end else begin
        px.pixel_x = other[aaring_pkg::PIX_W-1:0];
        px.pixel_y = pos[aaring_pkg::PIX_W-1:0];
      end
    end
    return px;
  endfunction

  // Stimulus
  initial begin
    int unsigned r, t;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = aaring_pkg::REG_RADIUS;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 256 px radius, 3 px stroke; corners, edges, ring crossing
    send_xy(0, 0);
    send_xy(1023, 1023);
    send_xy(511, 511);
    send_xy(512, 0);
    send_xy(0, 512);
    send_xy(256, 0);
    send_xy(256, 1);
    send_xy(256, 2);
    send_xy(256, 3);
    send_xy(256, 4);
    send_xy(256, 256);

    // zero radius: empty texture
    wait_drained();
    write_rings(0, 0);
    send_xy(0, 0);
    send_xy(1023, 1023);

    // largest radius and thickness
    wait_drained();
    write_rings(131071, 131071);
    send_xy(0, 0);
    send_xy(511, 511);
    send_xy(1022, 1022);
    send_xy(1023, 5);

    // largest radius, zero thickness: no core
    wait_drained();
    write_rings(131071, 0);
    send_xy(511, 0);
    send_xy(0, 511);
    send_xy(1022, 511);

    // stroke wider than the disc: stroke center ring below zero
    wait_drained();
    write_rings(256, 131071);
    send_xy(0, 0);
    send_xy(1, 1);
    send_xy(2, 0);

    // smallest nonzero radius
    wait_drained();
    write_rings(1, 5);
    send_xy(0, 0);

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      if (ph < 2) begin
        send_idle = 28;
        recv_idle = 77;
      end else if (ph < 4) begin
        send_idle = 77;
        recv_idle = 28;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (ph)
        0: begin
          r = $urandom_range(256, 8192);
          t = $urandom_range(0, 1024);
        end
        1: begin
          r = $urandom_range(1, 131071);
          t = $urandom_range(0, 131071);
        end
        2: begin
          r = 131071;
          t = $urandom_range(0, 4096);
        end
        3: begin
          r = $urandom_range(512, 32768);
          t = 0;
        end
        4: begin
          r = $urandom_range(1024, 131071);
          t = 131071;
        end
        default: begin
          r = $urandom_range(2048, 65536);
          t = $urandom_range(256, 3072);
        end
      endcase
      write_rings(r, t);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sender holds off mid-phase until the pipeline has emptied
        if (i == PHASE_ITEMS / 2) wait_drained();
        send_texel(random_texel(r, t));
      end
    end

    wait_drained();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_antialiased_ring_alpha OK");
    end else begin
      $display("tb_antialiased_ring_alpha NOT OK");
    end
    $finish;
  end

endmodule
